>>> src/vignette_gain_correction_core_assert.svh
// ----------------------------------------------------------------------------
// Vignette gain correction assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef VIGNETTE_GAIN_CORRECTION_CORE_ASSERT_SVH
`define VIGNETTE_GAIN_CORRECTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define VGC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vgc assertion failed");
`define VGC_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("vgc assertion failed");
`else
`define VGC_ASSERT(label, clk, rst_n, prop)
`define VGC_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> src/vgc_pkg.sv
// ----------------------------------------------------------------------------
// Vignette gain correction package
// Widths, constants, payload types and helpers shared by the core and lanes.
// ----------------------------------------------------------------------------
package vgc_pkg;

    localparam int SMP_W     = 8;
    localparam int ROW_W     = 10;
    localparam int DIM_W     = 11;
    localparam int MAX_DIM   = 1024;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_LANES = 3;

    localparam int DIST_SHIFT = 9;
    localparam int DIFF_W     = ROW_W;
    localparam int AX_Q_W     = DIST_SHIFT;
    localparam int AX_REM_W   = DIFF_W + DIST_SHIFT;

    localparam int HALF_SPAN    = 256;
    localparam int PITCH_NUM    = 128;
    localparam int PITCH_DEN    = 100;
    localparam int PITCHED_HALF = (HALF_SPAN * PITCH_NUM) / PITCH_DEN;
    localparam int X_W          = 9;

    // Scaling by 128/100 is a multiply by a rounded-up reciprocal. The error
    // stays far below 1/25 over the whole distance range, so the floor is exact.
    localparam int PITCH_SHIFT   = 12;
    localparam int PITCH_RECIP_W = 13;
    localparam logic [PITCH_RECIP_W-1:0] PITCH_RECIP =
        PITCH_RECIP_W'(((1 << PITCH_SHIFT) * PITCH_NUM + PITCH_DEN - 1) / PITCH_DEN);
    localparam int PROD_W = AX_Q_W + PITCH_RECIP_W;

    localparam int SQ_W       = 2 * X_W;
    localparam int DEN_W      = 18;
    localparam int GAIN_K_VAL = 2 * PITCHED_HALF * PITCHED_HALF;
    localparam logic [DEN_W-1:0] GAIN_K  = DEN_W'(GAIN_K_VAL);
    localparam logic [DEN_W-1:0] DEN_MIN =
        DEN_W'(GAIN_K_VAL - PITCHED_HALF * PITCHED_HALF - HALF_SPAN * HALF_SPAN);
    localparam int NUM_W = DEN_W + SMP_W;
    localparam logic [SMP_W-1:0] SAT_MAX = SMP_W'(255);

    localparam int LANE_STAGES = SMP_W + 2;

    localparam int   ROWS_RST  = 496;
    localparam int   COLS_RST  = 512;
    localparam logic COLOR_RST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS = 2'd0,
        CFG_FRAME_COLS = 2'd1,
        CFG_COLOR_MODE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] pixel_row;
        logic [ROW_W-1:0] pixel_col;
        logic [SMP_W-1:0] sample_a;
        logic [SMP_W-1:0] sample_b;
        logic [SMP_W-1:0] sample_c;
    } t_pix_in;

    typedef struct packed {
        logic [SMP_W-1:0] out_a;
        logic [SMP_W-1:0] out_b;
        logic [SMP_W-1:0] out_c;
    } t_pix_out;

    typedef logic [NUM_LANES-1:0][SMP_W-1:0] t_smp_vec;

    function automatic logic [DIM_W-1:0] f_clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

>>> src/vignette_gain_correction_core.sv
// ----------------------------------------------------------------------------
// Vignette gain correction core
// Throughput: one request per cycle while the output is not stalled; each divider stage resolves one quotient bit.
// Reset: synchronous, active low; flushes all requests and restores the registers.
// ----------------------------------------------------------------------------
`include "vignette_gain_correction_core_assert.svh"

module vignette_gain_correction_core
    import vgc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pix_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_pix_out             o_out_data
);

    logic [DIM_W-1:0] r_rows;
    logic [ROW_W-1:0] r_rows_last;
    logic [DIM_W-1:0] r_cols;
    logic [ROW_W-1:0] r_cols_last;
    logic             r_color_mode;
    logic [DIM_W-1:0] wdata_dim;
    logic [ROW_W-1:0] wdata_last;

    logic adv;
    logic take_in;

    logic             r_a_vld;
    logic [ROW_W-1:0] r_a_row;
    logic [ROW_W-1:0] r_a_col;
    t_smp_vec         r_a_smp;

    logic              r_b_vld;
    logic [DIFF_W-1:0] r_b_drow;
    logic [DIFF_W-1:0] r_b_dcol;
    t_smp_vec          r_b_smp;
    logic [ROW_W-1:0]  half_row;
    logic [ROW_W-1:0]  half_col;

    logic [AX_Q_W-1:0]           y_quo;
    logic [AX_Q_W-1:0]           x_quo;
    logic [AX_Q_W-1:0]           r_ax_vld;
    t_smp_vec [AX_Q_W-1:0]       r_ax_smp;

    logic [PROD_W-1:0] x_prod;
    logic              r_p_vld;
    logic [X_W-1:0]    r_p_x;
    logic [AX_Q_W-1:0] r_p_y;
    t_smp_vec          r_p_smp;

    logic              r_q_vld;
    logic [SQ_W-1:0]   r_q_xx;
    logic [SQ_W-1:0]   r_q_yy;
    t_smp_vec          r_q_smp;

    logic              r_r_vld;
    logic [DEN_W-1:0]  r_r_den;
    t_smp_vec          r_r_smp;

    t_smp_vec               lane_out;
    logic [LANE_STAGES-1:0] r_ln_vld;

    logic     r_out_vld;
    t_pix_out r_out_data;
    t_pix_out n_out_data;

    assign wdata_dim  = f_clamp_dim(i_cfg_wdata);
    assign wdata_last = ROW_W'(wdata_dim - DIM_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= DIM_W'(ROWS_RST);
            r_rows_last  <= ROW_W'(ROWS_RST - 1);
            r_cols       <= DIM_W'(COLS_RST);
            r_cols_last  <= ROW_W'(COLS_RST - 1);
            r_color_mode <= COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_ROWS: begin
                    r_rows      <= wdata_dim;
                    r_rows_last <= wdata_last;
                end
                CFG_FRAME_COLS: begin
                    r_cols      <= wdata_dim;
                    r_cols_last <= wdata_last;
                end
                CFG_COLOR_MODE: begin
                    r_color_mode <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline holds while the output register waits on the consumer.
    assign adv        = !(r_out_vld && i_out_stall);
    assign o_in_stall = !adv;
    assign take_in    = i_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_ax_vld  <= '0;
            r_p_vld   <= 1'b0;
            r_q_vld   <= 1'b0;
            r_r_vld   <= 1'b0;
            r_ln_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld   <= take_in;
            r_b_vld   <= r_a_vld;
            r_ax_vld  <= {r_ax_vld[AX_Q_W-2:0], r_b_vld};
            r_p_vld   <= r_ax_vld[AX_Q_W-1];
            r_q_vld   <= r_p_vld;
            r_r_vld   <= r_q_vld;
            r_ln_vld  <= {r_ln_vld[LANE_STAGES-2:0], r_r_vld};
            r_out_vld <= r_ln_vld[LANE_STAGES-1];
        end
    end

    assign half_row = r_rows[DIM_W-1:1];
    assign half_col = r_cols[DIM_W-1:1];
    assign x_prod   = PROD_W'(x_quo) * PROD_W'(PITCH_RECIP);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_row <= (i_in_data.pixel_row > r_rows_last) ? r_rows_last
                                                           : i_in_data.pixel_row;
            r_a_col <= (i_in_data.pixel_col > r_cols_last) ? r_cols_last
                                                           : i_in_data.pixel_col;
            r_a_smp <= {i_in_data.sample_c, i_in_data.sample_b, i_in_data.sample_a};

            r_b_drow <= (half_row > r_a_row) ? half_row - r_a_row : r_a_row - half_row;
            r_b_dcol <= (half_col > r_a_col) ? half_col - r_a_col : r_a_col - half_col;
            r_b_smp  <= r_a_smp;

            r_ax_smp <= {r_ax_smp[AX_Q_W-2:0], r_b_smp};

            r_p_x   <= x_prod[PITCH_SHIFT +: X_W];
            r_p_y   <= y_quo;
            r_p_smp <= r_ax_smp[AX_Q_W-1];

            r_q_xx  <= SQ_W'(r_p_x) * SQ_W'(r_p_x);
            r_q_yy  <= SQ_W'(r_p_y) * SQ_W'(r_p_y);
            r_q_smp <= r_p_smp;

            r_r_den <= GAIN_K - r_q_xx - r_q_yy;
            r_r_smp <= r_q_smp;

            r_out_data <= n_out_data;
        end
    end

    vgc_axis_div u_row_div (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_diff (r_b_drow),
        .i_den  (r_rows),
        .o_quo  (y_quo)
    );

    vgc_axis_div u_col_div (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_diff (r_b_dcol),
        .i_den  (r_cols),
        .o_quo  (x_quo)
    );

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        vgc_gain_lane u_lane (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_smp (r_r_smp[l]),
            .i_den (r_r_den),
            .o_smp (lane_out[l])
        );
    end

    always_comb begin
        n_out_data.out_a = lane_out[0];
        n_out_data.out_b = r_color_mode ? lane_out[1] : '0;
        n_out_data.out_c = r_color_mode ? lane_out[2] : '0;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    `VGC_ASSERT(a_mono_quiet, i_clk, i_rst_n, o_out_valid && !r_color_mode |-> o_out_data.out_b == '0 && o_out_data.out_c == '0)
    `VGC_ASSERT(a_den_floor, i_clk, i_rst_n, r_r_vld |-> r_r_den >= DEN_MIN)
    `VGC_ASSERT(a_radius_bound, i_clk, i_rst_n, r_p_vld |-> r_p_x <= X_W'(PITCHED_HALF) && r_p_y <= AX_Q_W'(HALF_SPAN))
    `VGC_ASSERT_NORST(a_reset_flush, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

>>> src/vgc_axis_div.sv
// ----------------------------------------------------------------------------
// Axis distance divider
// Pipelined restoring divider giving diff * 512 / dim, one quotient bit a stage.
// ----------------------------------------------------------------------------
module vgc_axis_div
    import vgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIFF_W-1:0] i_diff,
    input  logic [DIM_W-1:0]  i_den,
    output logic [AX_Q_W-1:0] o_quo
);

    logic [AX_REM_W-1:0] r_rem [AX_Q_W-1];
    logic [AX_Q_W-1:0]   r_quo [AX_Q_W];

    for (genvar k = 0; k < AX_Q_W; k++) begin : g_step
        logic [AX_REM_W-1:0] rem_in;
        logic [AX_Q_W-1:0]   quo_in;
        logic [AX_REM_W-1:0] trial;
        logic                take;

        if (k == 0) begin : g_head
            assign rem_in = {i_diff, {DIST_SHIFT{1'b0}}};
            assign quo_in = '0;
        end else begin : g_body
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = AX_REM_W'(i_den) << (AX_Q_W - 1 - k);
        assign take  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_in[AX_Q_W-2:0], take};
            end
        end

        if (k < AX_Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? rem_in - trial : rem_in;
                end
            end
        end
    end

    assign o_quo = r_quo[AX_Q_W-1];

endmodule

>>> src/vgc_gain_lane.sv
// ----------------------------------------------------------------------------
// Gain lane
// Computes min(255, K * sample / den) for one sample with a bit-per-stage divider.
// ----------------------------------------------------------------------------
module vgc_gain_lane
    import vgc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SMP_W-1:0] i_smp,
    input  logic [DEN_W-1:0] i_den,
    output logic [SMP_W-1:0] o_smp
);

    logic [NUM_W-1:0] r_mul_num;
    logic [DEN_W-1:0] r_mul_den;
    logic [NUM_W-1:0] r_chk_num;
    logic [DEN_W-1:0] r_chk_den;
    logic             r_chk_sat;
    logic [NUM_W-1:0] r_rem [SMP_W-1];
    logic [DEN_W-1:0] r_den [SMP_W-1];
    logic [SMP_W-1:0] r_quo [SMP_W];
    logic             r_sat [SMP_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mul_num <= GAIN_K * NUM_W'(i_smp);
            r_mul_den <= i_den;
            r_chk_num <= r_mul_num;
            r_chk_den <= r_mul_den;
            r_chk_sat <= r_mul_num >= {r_mul_den, {SMP_W{1'b0}}};
        end
    end

    for (genvar j = 0; j < SMP_W; j++) begin : g_bit
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [SMP_W-1:0] quo_in;
        logic             sat_in;
        logic [NUM_W-1:0] trial;
        logic             take;

        if (j == 0) begin : g_head
            assign rem_in = r_chk_num;
            assign den_in = r_chk_den;
            assign quo_in = '0;
            assign sat_in = r_chk_sat;
        end else begin : g_body
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign sat_in = r_sat[j-1];
        end

        assign trial = NUM_W'(den_in) << (SMP_W - 1 - j);
        assign take  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= {quo_in[SMP_W-2:0], take};
                r_sat[j] <= sat_in;
            end
        end

        if (j < SMP_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= take ? rem_in - trial : rem_in;
                    r_den[j] <= den_in;
                end
            end
        end
    end

    assign o_smp = r_sat[SMP_W-1] ? SAT_MAX : r_quo[SMP_W-1];

endmodule

>>> tb/vgc_gain_checker.sv
// ----------------------------------------------------------------------------
// Vignette gain correction checker
// Watches the configuration port and both request channels, predicts the
// corrected pixel for every accepted request from its own copy of the frame
// registers, and compares each returned pixel field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgc_gain_checker
    import vgc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_pix_in              i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_pix_out             i_out_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int unsigned FALLOFF_K  = GAIN_K_VAL;
    localparam int unsigned AXIS_SCALE = 1 << DIST_SHIFT;
    localparam int          REPORT_MAX = 10;

    logic [DIM_W-1:0] rows_cfg;
    logic [DIM_W-1:0] cols_cfg;
    logic             color_cfg;
    t_pix_out         expected_pix[$];
    int               mismatch_count = 0;
    int               checked_count  = 0;

    function automatic int unsigned clamp_span(input logic [DIM_W-1:0] v);
        int unsigned span;
        span = v;
        if (span == 0) begin
            span = 1;
        end else if (span > MAX_DIM) begin
            span = MAX_DIM;
        end
        return span;
    endfunction

    function automatic logic [SMP_W-1:0] boost(input logic [SMP_W-1:0] s,
                                               input int unsigned dsq);
        int unsigned q;
        q = (FALLOFF_K * s) / (FALLOFF_K - dsq);
        return (q > 255) ? SAT_MAX : q[SMP_W-1:0];
    endfunction

    function automatic t_pix_out predict_corrected(input t_pix_in p);
        int unsigned rows, cols, row, col, dy, dx, y, x, dsq;
        t_pix_out    res;
        rows = clamp_span(rows_cfg);
        cols = clamp_span(cols_cfg);
        row  = p.pixel_row;
        col  = p.pixel_col;
        if (row > rows - 1) begin
            row = rows - 1;
        end
        if (col > cols - 1) begin
            col = cols - 1;
        end
        dy  = (rows / 2 > row) ? rows / 2 - row : row - rows / 2;
        dx  = (cols / 2 > col) ? cols / 2 - col : col - cols / 2;
        y   = dy * AXIS_SCALE / rows;
        x   = (dx * AXIS_SCALE / cols) * PITCH_NUM / PITCH_DEN;
        dsq = x * x + y * y;
        res.out_a = boost(p.sample_a, dsq);
        res.out_b = color_cfg ? boost(p.sample_b, dsq) : '0;
        res.out_c = color_cfg ? boost(p.sample_c, dsq) : '0;
        return res;
    endfunction

    function automatic void compare_field(input string fname,
                                          input logic [SMP_W-1:0] exp_v,
                                          input logic [SMP_W-1:0] got_v);
        if (got_v !== exp_v) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
                $display("%0t: %s expected %0d, got %0d", $time, fname, exp_v, got_v);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_pix_out exp_pix;
        if (!i_rst_n) begin
            rows_cfg  = DIM_W'(ROWS_RST);
            cols_cfg  = DIM_W'(COLS_RST);
            color_cfg = COLOR_RST;
            expected_pix.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_pix.push_back(predict_corrected(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pix.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("%0t: unexpected pixel a=%0d b=%0d c=%0d", $time,
                                 i_out_data.out_a, i_out_data.out_b, i_out_data.out_c);
                    end
                end else begin
                    exp_pix = expected_pix.pop_front();
                    checked_count++;
                    compare_field("out_a", exp_pix.out_a, i_out_data.out_a);
                    compare_field("out_b", exp_pix.out_b, i_out_data.out_b);
                    compare_field("out_c", exp_pix.out_c, i_out_data.out_c);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_ROWS: rows_cfg = i_cfg_wdata;
                    CFG_FRAME_COLS: cols_cfg = i_cfg_wdata;
                    CFG_COLOR_MODE: color_cfg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        o_mismatches = mismatch_count;
        o_pending    = expected_pix.size();
        o_checked    = checked_count;
    end

endmodule

>>> tb/tb_vignette_gain_correction_core.sv
// ----------------------------------------------------------------------------
// Vignette gain correction core testbench
// Drives directed edge pixels and random pixels through a series of frame
// settings, including zero, oversized and mono setups, under changing idle,
// stall and back-pressure patterns; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vignette_gain_correction_core;
    import vgc_pkg::*;

    localparam int NUM_PHASES       = 8;
    localparam int RANDOM_PER_PHASE = 155;
    localparam int DRAIN_CYCLES     = 40;
    localparam int HOLD_CYCLES      = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    t_pix_in              in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_pix_out             out_data;

    int mismatches;
    int pending;
    int checked;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_left     = 0;
    int pixels_sent   = 0;
    int rows_eff      = ROWS_RST;
    int cols_eff      = COLS_RST;

    int phase_rows[NUM_PHASES]  = '{496, 1024, 0, 2047, 1, -1, 480, -1};
    int phase_cols[NUM_PHASES]  = '{512, 1024, 0, 1, 1500, -1, 640, -1};
    int phase_color[NUM_PHASES] = '{1, 1, 0, 1, 0, -1, 1, -1};

    vignette_gain_correction_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    vgc_gain_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d pixels still outstanding.", pending);
        $display("vignette_gain_correction_core: mismatch");
        $finish;
    end

    initial begin
        out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < rcv_stall_pct);
            end
        end
    end

    function automatic t_pix_in mk_pixel(input int row, input int col,
                                         input int a, input int b, input int c);
        t_pix_in p;
        p.pixel_row = ROW_W'(row);
        p.pixel_col = ROW_W'(col);
        p.sample_a  = SMP_W'(a);
        p.sample_b  = SMP_W'(b);
        p.sample_c  = SMP_W'(c);
        return p;
    endfunction

    function automatic int pick_coord(input int span);
        case ($urandom_range(9))
            8: return $urandom_range(1023);
            9: return ($urandom_range(1) != 0) ? span - 1 : 0;
            default: return $urandom_range(span - 1);
        endcase
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic send_pixel(input t_pix_in p);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < snd_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (in_stall);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic apply_frame(input int rows, input int cols, input int color);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_FRAME_ROWS;
        cfg_wdata <= DIM_W'(rows);
        @(negedge i_clk);
        cfg_idx   <= CFG_FRAME_COLS;
        cfg_wdata <= DIM_W'(cols);
        @(negedge i_clk);
        cfg_idx   <= CFG_COLOR_MODE;
        cfg_wdata <= DIM_W'(color);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        rows_eff = (rows == 0) ? 1 : ((rows > MAX_DIM) ? MAX_DIM : rows);
        cols_eff = (cols == 0) ? 1 : ((cols > MAX_DIM) ? MAX_DIM : cols);
    endtask

    initial begin
        int rows, cols, color;
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_FRAME_ROWS;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                rows  = (phase_rows[ph] < 0) ? $urandom_range(1, 1024) : phase_rows[ph];
                cols  = (phase_cols[ph] < 0) ? $urandom_range(1, 1024) : phase_cols[ph];
                color = (phase_color[ph] < 0) ? $urandom_range(1) : phase_color[ph];
                apply_frame(rows, cols, color);
            end
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
                default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
            endcase
            if (ph == 0) begin
                send_pixel(mk_pixel(0, 0, 0, 0, 0));
                send_pixel(mk_pixel(0, 0, 255, 255, 255));
                send_pixel(mk_pixel(248, 256, 255, 128, 1));
                send_pixel(mk_pixel(248, 256, 0, 0, 0));
                send_pixel(mk_pixel(495, 511, 255, 255, 255));
                send_pixel(mk_pixel(495, 511, 100, 150, 200));
                send_pixel(mk_pixel(0, 511, 200, 100, 50));
                send_pixel(mk_pixel(495, 0, 1, 2, 3));
                send_pixel(mk_pixel(0, 256, 170, 85, 15));
                send_pixel(mk_pixel(248, 0, 129, 126, 240));
                send_pixel(mk_pixel(1023, 1023, 255, 255, 255));
                send_pixel(mk_pixel(1023, 256, 90, 91, 92));
                send_pixel(mk_pixel(248, 1023, 60, 61, 62));
                send_pixel(mk_pixel(512, 700, 170, 85, 240));
                send_pixel(mk_pixel(341, 682, 255, 0, 255));
                send_pixel(mk_pixel(123, 456, 0, 255, 0));
                // The receiver holds off while requests keep coming, so the
                // pipeline fills and pushes back on the input.
                hold_left = HOLD_CYCLES;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_pixel(mk_pixel(pick_coord(rows_eff), pick_coord(cols_eff),
                                    pick_sample(), pick_sample(), pick_sample()));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d pixels over %0d frame setups (mono, color, zero and oversized).",
                 pixels_sent, NUM_PHASES);
        $display("Compared %0d results under idle, stall and long back-pressure periods.",
                 checked);
        if (mismatches == 0 && pending == 0) begin
            $display("vignette_gain_correction_core: match");
        end else begin
            $display("vignette_gain_correction_core: mismatch");
        end
        $finish;
    end

endmodule
